// ===== rtl/mf3_pkg.sv =====
// shared types and constants for the 3x3 rgb median filter
// no dependencies; used by the top level and by mf3_median9
`default_nettype none

package mf3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int SAMPLE_W    = 8;
    localparam int PIX_W       = 4 * SAMPLE_W;
    localparam int OUT_COL_W   = 10;
    localparam int OUT_ROW_W   = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int IMG_W_W     = 11;
    localparam int IMG_H_W     = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_ALPHA    = 2'd2;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_in;
        logic [SAMPLE_W-1:0] green_in;
        logic [SAMPLE_W-1:0] blue_in;
        logic [SAMPLE_W-1:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  red_out;
        logic [SAMPLE_W-1:0]  green_out;
        logic [SAMPLE_W-1:0]  blue_out;
        logic [SAMPLE_W-1:0]  alpha_out;
        logic [OUT_COL_W-1:0] out_column;
        logic [OUT_ROW_W-1:0] out_row;
    } t_pix_out;

    typedef logic [8:0][SAMPLE_W-1:0] t_samples9;

endpackage

`default_nettype wire

// ===== rtl/median_filter_3x3_rgb_top.sv =====
// top level of the 3x3 rgb median filter
// depends on mf3_pkg, mf3_ram and mf3_median9
//
// pixels enter in raster order on the input channel (i_in_valid, o_in_stall,
// i_in_data); one word is taken at each edge with valid high and stall low.
// results leave on the output channel (o_out_valid, i_out_stall, o_out_data)
// with their column and row. a result belongs to the pixel one row and one
// column behind the newest input, so the first width+1 pixels of a frame give
// no result and the last width+1 positions are never sent. border results
// are all zeros.
// throughput is one pixel per clock while the receiver does not stall; the input
// that completes a window passes the read stage (line buffer read), then the median
// and output register. the line buffers are one ram with a registered read port.
// reset clears the handshake state, the frame position and the registers to
// 640 x 480 without alpha; line buffer contents are left as they are.
// a register write restarts the frame at column and row zero.
// while the receiver stalls, one more pixel is still taken into the read
// stage; further input is stalled only when that pixel has a result to send.
`default_nettype none

module median_filter_3x3_rgb_top #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mf3_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire mf3_pkg::t_pix_in                   i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output mf3_pkg::t_pix_out                       o_out_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = mf3_pkg::PIX_W;
    localparam int SW = mf3_pkg::SAMPLE_W;

    // configuration
    logic [mf3_pkg::IMG_W_W-1:0] r_img_w;
    logic [mf3_pkg::IMG_H_W-1:0] r_img_h;
    logic                        r_alpha_en;
    logic                        cfg_hit;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    // frame position of the next input word
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [WW:0]   col_inc;
    logic [HW:0]   row_inc;

    // read stage
    logic                        r_s1_valid;
    logic [PW-1:0]               r_s1_pix;
    logic [CW-1:0]               r_s1_addr;
    logic                        r_s1_emit;
    logic                        r_s1_interior;
    logic [mf3_pkg::OUT_COL_W-1:0] r_s1_col;
    logic [mf3_pkg::OUT_ROW_W-1:0] r_s1_row;

    logic           accept;
    logic           out_free;
    logic           s1_fire;
    logic           emit;
    logic           interior;
    logic           col_nz;
    logic [WW-1:0]  oc;
    logic [RW-1:0]  orow;
    logic [31:0]    oc32;
    logic [31:0]    orow32;

    logic [2*PW-1:0] ram_rdata;
    logic [PW-1:0]   above_rd;
    logic [PW-1:0]   two_above_rd;

    logic [PW-1:0] r_win [9];
    logic [PW-1:0] n_win [9];

    mf3_pkg::t_samples9 samp_r, samp_g, samp_b;
    logic [SW-1:0]      med_r, med_g, med_b;

    logic              r_out_valid;
    mf3_pkg::t_pix_out r_out;

    always_comb begin
        if (32'(r_img_w) < 32'd3) begin
            w_eff = WW'(3);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_img_w);
        end
        if (32'(r_img_h) < 32'd3) begin
            h_eff = HW'(3);
        end else if (32'(r_img_h) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_img_h);
        end
    end

    always_comb begin
        case (i_cfg_index)
            mf3_pkg::CFG_IMAGE_WIDTH:  cfg_hit = 1'b1;
            mf3_pkg::CFG_IMAGE_HEIGHT: cfg_hit = 1'b1;
            mf3_pkg::CFG_HAS_ALPHA:    cfg_hit = 1'b1;
            default:                   cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= mf3_pkg::IMAGE_WIDTH_RST;
            r_img_h    <= mf3_pkg::IMAGE_HEIGHT_RST;
            r_alpha_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mf3_pkg::CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[mf3_pkg::IMG_W_W-1:0];
                mf3_pkg::CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[mf3_pkg::IMG_H_W-1:0];
                mf3_pkg::CFG_HAS_ALPHA:    r_alpha_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && (!r_s1_emit || out_free);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign accept     = i_in_valid && !o_in_stall;

    // position bookkeeping
    always_comb begin
        col_inc = (WW + 1)'(r_col) + (WW + 1)'(1);
        row_inc = (HW + 1)'(r_row) + (HW + 1)'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (col_inc >= (WW + 1)'(w_eff)) begin
            n_col = '0;
            if (row_inc >= (HW + 1)'(h_eff)) begin
                n_row = '0;
            end else begin
                n_row = RW'(row_inc);
            end
        end else begin
            n_col = CW'(col_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we && cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // result position and border flags for the pixel that completes a window
    always_comb begin
        col_nz   = (r_col != '0);
        emit     = (r_row >= RW'(2)) || ((r_row == RW'(1)) && col_nz);
        interior = (r_row >= RW'(2)) && (r_col >= CW'(2));
        if (col_nz) begin
            oc   = WW'(r_col) - WW'(1);
            orow = r_row - RW'(1);
        end else begin
            oc   = w_eff - WW'(1);
            orow = r_row - RW'(2);
        end
        oc32   = 32'(oc);
        orow32 = 32'(orow);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= {i_in_data.alpha_in, i_in_data.blue_in,
                              i_in_data.green_in, i_in_data.red_in};
            r_s1_addr     <= r_col;
            r_s1_emit     <= emit;
            r_s1_interior <= interior;
            r_s1_col      <= oc32[mf3_pkg::OUT_COL_W-1:0];
            r_s1_row      <= orow32[mf3_pkg::OUT_ROW_W-1:0];
        end
    end

    // both line buffers in one word: upper half the row above, lower half two above
    mf3_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_addr),
        .i_wdata ({r_s1_pix, above_rd}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign above_rd     = ram_rdata[2*PW-1:PW];
    assign two_above_rd = ram_rdata[PW-1:0];

    // window shifts left, newest column on the right
    always_comb begin
        for (int rr = 0; rr < 3; rr++) begin
            n_win[rr*3 + 0] = r_win[rr*3 + 1];
            n_win[rr*3 + 1] = r_win[rr*3 + 2];
        end
        n_win[2] = two_above_rd;
        n_win[5] = above_rd;
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            samp_r[k] = n_win[k][SW-1:0];
            samp_g[k] = n_win[k][2*SW-1:SW];
            samp_b[k] = n_win[k][3*SW-1:2*SW];
        end
    end

    mf3_median9 u_med_r (.i_samples(samp_r), .o_median(med_r));
    mf3_median9 u_med_g (.i_samples(samp_g), .o_median(med_g));
    mf3_median9 u_med_b (.i_samples(samp_b), .o_median(med_b));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            if (r_s1_interior) begin
                r_out.red_out   <= med_r;
                r_out.green_out <= med_g;
                r_out.blue_out  <= med_b;
                r_out.alpha_out <= r_alpha_en ? n_win[4][4*SW-1:3*SW] : '0;
            end else begin
                r_out.red_out   <= '0;
                r_out.green_out <= '0;
                r_out.blue_out  <= '0;
                r_out.alpha_out <= '0;
            end
            r_out.out_column <= r_s1_col;
            r_out.out_row    <= r_s1_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/mf3_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module mf3_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mf3_median9.sv =====
// median of nine 8-bit samples by parallel rank counting
// depends on mf3_pkg
`default_nettype none

module mf3_median9 (
    input  wire mf3_pkg::t_samples9             i_samples,
    output logic [mf3_pkg::SAMPLE_W-1:0]        o_median
);

    logic [3:0] rank [9];
    logic [mf3_pkg::SAMPLE_W-1:0] med;

    // ties broken by position so exactly one sample has rank four
    always_comb begin
        med = '0;
        for (int i = 0; i < 9; i++) begin
            rank[i] = 4'd0;
            for (int j = 0; j < 9; j++) begin
                if (j != i) begin
                    if ((i_samples[j] < i_samples[i]) ||
                        ((i_samples[j] == i_samples[i]) && (j < i))) begin
                        rank[i] = rank[i] + 4'd1;
                    end
                end
            end
            if (rank[i] == 4'd4) begin
                med = med | i_samples[i];
            end
        end
    end

    assign o_median = med;

endmodule

`default_nettype wire
